// ----- design/cna_pkg.sv -----
`timescale 1ns / 1ps

package cna_pkg;

  localparam int IN_FRAC_BITS  = 24;
  localparam int OUT_FRAC_BITS = 31;

  // internal formats
  localparam int QF  = 40;                         // working fraction bits
  localparam int RF  = 56;                         // ratio fraction bits
  localparam int XW  = 32;                         // input field width
  localparam int AFW = XW + QF - IN_FRAC_BITS;     // |x| in Q.40, full range
  localparam int AW  = 46;                         // |x| in Q.40, up to 37
  localparam int KW  = 11;                         // exponent of 2 for exp()
  localparam int TW  = 48;                         // series term width
  localparam int TW_HALF  = TW / 2;

  localparam int DIV_STEPS    = 64;
  localparam int TAYLOR_TERMS = 16;
  localparam int P_TERMS      = 7;
  localparam int Q_TERMS      = 8;
  localparam int CF_LEVELS    = 4;

  typedef logic [63:0] q64_t;

  typedef struct packed {
    logic [63:0] hh;
    logic [63:0] hl;
    logic [63:0] lh;
    logic [63:0] ll;
  } mparts_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] nq;     // numerator low bits shifting out, quotient shifting in
    logic [63:0] den;
  } div_state_t;

  // payload carried down the pipe
  typedef struct packed {
    logic          pos;
    logic          far;
    logic          rat;
    logic [AW-1:0] a;
    logic [KW-1:0] k;
    q64_t          u;
    logic [TW-1:0] term;
    q64_t          m;
    q64_t          pn;
    q64_t          qd;
    q64_t          b;
  } pipe_t;

  function automatic q64_t pow10(input int e);
    q64_t v;
    v = 64'd1;
    for (int i = 0; i < e; i++) v = v * 64'd10;
    return v;
  endfunction

  // round(num / 10^e10 * 2^QF), shift-subtract only; elaboration use
  function automatic q64_t to_q(input q64_t num, input int e10);
    q64_t        d;
    q64_t        q;
    logic [64:0] r;
    d = pow10(e10);
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      q = {q[62:0], 1'b0};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[0] = 1'b1;
      end
    end
    for (int i = 0; i < QF; i++) begin
      r = {r[63:0], 1'b0};
      q = {q[62:0], 1'b0};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[0] = 1'b1;
      end
    end
    r = {r[63:0], 1'b0};
    if (r >= {1'b0, d}) q = q + 64'd1;
    return q;
  endfunction

  // ceil(2^s / n); elaboration use, constant arguments only
  function automatic logic [32:0] recip(input int n, input int s);
    logic [63:0] p;
    p = (64'd1 << s) + 64'(n) - 64'd1;
    return 33'(p / 64'(n));
  endfunction

  localparam q64_t P_COEF [P_TERMS] = '{
    to_q(64'd352624965998911, 16), to_q(64'd700383064443688, 15),
    to_q(64'd637396220353165, 14), to_q(64'd33912866078383, 12),
    to_q(64'd112079291497871, 12), to_q(64'd221213596169931, 12),
    to_q(64'd220206867912376, 12)
  };

  localparam q64_t Q_COEF [Q_TERMS] = '{
    to_q(64'd883883476483184, 16), to_q(64'd175566716318264, 14),
    to_q(64'd16064177579207, 12),  to_q(64'd867807322029461, 13),
    to_q(64'd296564248779674, 12), to_q(64'd637333633378831, 12),
    to_q(64'd793826512519948, 12), to_q(64'd440413735824752, 12)
  };

  localparam q64_t SQRT50_Q  = to_q(64'd707106781186547, 14);
  localparam q64_t C065_Q    = to_q(64'd65, 2);
  localparam q64_t SQRT2PI_Q = to_q(64'd2506628274631, 12);
  localparam q64_t LOG2E_Q   = to_q(64'd14426950408889634, 16);
  localparam q64_t LN2_Q     = to_q(64'd6931471805599453, 16);
  localparam q64_t ONE_Q     = 64'd1 << QF;
  localparam q64_t FAR_Q     = 64'd37 << QF;
  localparam q64_t ONE_OUT   = 64'd1 << OUT_FRAC_BITS;

  // numerator coefficient for Horner step i; zero past the last one
  function automatic q64_t p_add(input int i);
    q64_t c;
    c = '0;
    if (i < P_TERMS) c = P_COEF[i];
    return c;
  endfunction

  // four 32x32 partial products
  function automatic mparts_t mul_parts(input q64_t x, input q64_t y);
    mparts_t p;
    p.hh = x[63:32] * y[63:32];
    p.hl = x[63:32] * y[31:0];
    p.lh = x[31:0]  * y[63:32];
    p.ll = x[31:0]  * y[31:0];
    return p;
  endfunction

  // Q.40 product, rounded to nearest, low 64 bits kept
  function automatic q64_t mul_round(input mparts_t p);
    logic [127:0] s;
    s = {p.hh, 64'd0} + {32'd0, p.hl, 32'd0} + {32'd0, p.lh, 32'd0} + {64'd0, p.ll}
      + (128'd1 << (QF - 1));
    return s[QF+63:QF];
  endfunction

  // one restoring division step
  function automatic div_state_t div_step(input div_state_t s);
    div_state_t  o;
    logic [64:0] sh;
    o    = s;
    sh   = {s.rem, s.nq[63]};
    o.nq = {s.nq[62:0], 1'b0};
    if (sh >= {1'b0, s.den}) begin
      o.rem   = 64'(sh - {1'b0, s.den});
      o.nq[0] = 1'b1;
    end else begin
      o.rem = sh[63:0];
    end
    return o;
  endfunction

endpackage

// ----- design/cna_mul2.sv -----
`timescale 1ns / 1ps

// two-lane Q.40 multiply-add, two register stages
module cna_mul2 (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  cna_pkg::q64_t    x0_i,
  input  cna_pkg::q64_t    y0_i,
  input  cna_pkg::q64_t    c0_i,
  input  cna_pkg::q64_t    x1_i,
  input  cna_pkg::q64_t    y1_i,
  input  cna_pkg::q64_t    c1_i,
  input  cna_pkg::pipe_t   side_i,
  output logic             vld_o,
  output cna_pkg::q64_t    r0_o,
  output cna_pkg::q64_t    r1_o,
  output cna_pkg::pipe_t   side_o
);

  cna_pkg::mparts_t p0_q, p1_q;
  cna_pkg::q64_t    c0_q, c1_q, r0_q, r1_q;
  cna_pkg::pipe_t   s1_q, s2_q;
  logic             v1_q, v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q <= cna_pkg::mul_parts(x0_i, y0_i);
      p1_q <= cna_pkg::mul_parts(x1_i, y1_i);
      c0_q <= c0_i;
      c1_q <= c1_i;
      s1_q <= side_i;
      r0_q <= cna_pkg::mul_round(p0_q) + c0_q;
      r1_q <= cna_pkg::mul_round(p1_q) + c1_q;
      s2_q <= s1_q;
    end
  end

  assign vld_o  = v2_q;
  assign r0_o   = r0_q;
  assign r1_o   = r1_q;
  assign side_o = s2_q;

endmodule

// ----- design/cna_div.sv -----
`timescale 1ns / 1ps

// round(num / den), 64 quotient bits, one bit per stage
// expects num[127:64] < den
module cna_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [127:0]     num_i,
  input  cna_pkg::q64_t    den_i,
  input  cna_pkg::pipe_t   side_i,
  output logic             vld_o,
  output cna_pkg::q64_t    quo_o,
  output cna_pkg::pipe_t   side_o
);

  localparam int N = cna_pkg::DIV_STEPS;

  cna_pkg::div_state_t st_q [N+1];
  cna_pkg::pipe_t      sd_q [N+1];
  logic [N:0]          v_q;
  logic                vo_q;
  cna_pkg::q64_t       quo_q;
  cna_pkg::pipe_t      so_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      v_q  <= {v_q[N-1:0], vld_i};
      vo_q <= v_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0].rem <= num_i[127:64];
      st_q[0].nq  <= num_i[63:0];
      st_q[0].den <= den_i;
      sd_q[0]     <= side_i;
      for (int i = 1; i <= N; i++) begin
        st_q[i] <= cna_pkg::div_step(st_q[i-1]);
        sd_q[i] <= sd_q[i-1];
      end
      // round half up on the final remainder
      quo_q <= st_q[N].nq
             + 64'({st_q[N].rem, 1'b0} >= {1'b0, st_q[N].den});
      so_q  <= sd_q[N];
    end
  end

  assign vld_o  = vo_q;
  assign quo_o  = quo_q;
  assign side_o = so_q;

endmodule

// ----- design/cumulative_normal_approximation.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// input     in         in_valid_i / in_stall_o   x_value_i     (signed Q8.24)
// output    out        out_valid_o / out_stall_i probability_o (unsigned Q1.31)
//
// One transfer in per cycle, one result out per cycle when nothing stalls.
// The pipe depth is set by the five serial restoring dividers (66 stages each)
// and the 16-term exp series.
// rst_ni clears only the valid bits; data registers are left alone.
// A held result freezes the whole pipe; in_stall_o goes high in that cycle
// and every stage keeps its item, so nothing is dropped or repeated.
module cumulative_normal_approximation (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] x_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] probability_o
);

  localparam int NT = cna_pkg::TAYLOR_TERMS;
  localparam int NQ = cna_pkg::Q_TERMS;
  localparam int NC = cna_pkg::CF_LEVELS;

  // global advance: the pipe moves unless a finished result is held
  logic        en;
  logic        out_vld_q;
  logic [31:0] prob_q;

  assign en         = !(out_vld_q && out_stall_i);
  assign in_stall_o = !en;

  // ---------------------------------------------------------------------
  // Input stage: |x| into Q.40, region flags, accumulator seeds
  // ---------------------------------------------------------------------
  logic                         v0_q;
  cna_pkg::pipe_t               p0_q, p0_d;
  logic [cna_pkg::XW-1:0]       mag;
  logic [cna_pkg::AFW-1:0]      a_full;

  always_comb begin
    // two's complement magnitude; the most negative code stays 2^31
    mag    = x_value_i[31] ? (~x_value_i + 32'd1) : x_value_i;
    a_full = {mag, {(cna_pkg::QF - cna_pkg::IN_FRAC_BITS){1'b0}}};
    p0_d.pos  = !x_value_i[31] && (x_value_i != 32'd0);
    p0_d.far  = 64'(a_full) > cna_pkg::FAR_Q;
    p0_d.rat  = 64'(a_full) < cna_pkg::SQRT50_Q;
    p0_d.a    = a_full[cna_pkg::AW-1:0];
    p0_d.k    = '0;
    p0_d.u    = '0;
    p0_d.term = cna_pkg::ONE_Q[cna_pkg::TW-1:0];
    p0_d.m    = cna_pkg::ONE_Q;
    p0_d.pn   = cna_pkg::P_COEF[0];
    p0_d.qd   = cna_pkg::Q_COEF[0];
    p0_d.b    = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) p0_q <= p0_d;
  end

  // ---------------------------------------------------------------------
  // exp(-a^2/2) = m * 2^-(k+1): square, scale by log2(e), split k / f
  // ---------------------------------------------------------------------
  logic           vsq, vy, vu;
  cna_pkg::q64_t  rsq, ry, ru;
  cna_pkg::pipe_t psq, py, pk, pu, pu_set;

  cna_mul2 u_sq (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v0_q),
    .x0_i(64'(p0_q.a)), .y0_i(64'(p0_q.a)), .c0_i('0),
    .x1_i('0), .y1_i('0), .c1_i('0),
    .side_i(p0_q), .vld_o(vsq), .r0_o(rsq), .r1_o(), .side_o(psq)
  );

  // half square rounded, times log2(e)
  cna_mul2 u_log2e (
    .clk_i, .rst_ni, .en_i(en), .vld_i(vsq),
    .x0_i((rsq + 64'd1) >> 1), .y0_i(cna_pkg::LOG2E_Q), .c0_i('0),
    .x1_i('0), .y1_i('0), .c1_i('0),
    .side_i(psq), .vld_o(vy), .r0_o(ry), .r1_o(), .side_o(py)
  );

  always_comb begin
    pk   = py;
    pk.k = ry[cna_pkg::QF+cna_pkg::KW-1:cna_pkg::QF];
  end

  // u = (1 - f) * ln2, the series argument
  cna_mul2 u_ln2 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(vy),
    .x0_i(cna_pkg::ONE_Q - 64'(ry[cna_pkg::QF-1:0])), .y0_i(cna_pkg::LN2_Q),
    .c0_i('0), .x1_i('0), .y1_i('0), .c1_i('0),
    .side_i(pk), .vld_o(vu), .r0_o(ru), .r1_o(), .side_o(pu)
  );

  always_comb begin
    pu_set   = pu;
    pu_set.u = ru;
  end

  // ---------------------------------------------------------------------
  // Taylor series for exp(u): term_n = round(term * u) / n, m += term_n.
  // Four stages per term: multiply (2), then exact divide by the constant
  // n through a reciprocal multiply, high half then low half with the
  // remainder carried over, and the sum folded in last.
  // ---------------------------------------------------------------------
  cna_pkg::pipe_t tp [NT+1];
  logic [NT:0]    tv;

  assign tp[0] = pu_set;
  assign tv[0] = vu;

  for (genvar n = 1; n <= NT; n++) begin : g_taylor
    localparam int TermN = n;
    // floor(x / n) = (x * ceil(2^s / n)) >> s holds for x below 2^(s-4)
    localparam int          ShH  = cna_pkg::TW_HALF + 4;
    localparam int          ShL  = cna_pkg::TW_HALF + 8;
    localparam logic [32:0] MulH = cna_pkg::recip(TermN, ShH);
    localparam logic [32:0] MulL = cna_pkg::recip(TermN, ShL);

    logic                         mv;
    cna_pkg::q64_t                mr;
    cna_pkg::pipe_t               mp;
    logic                         ta_v_q, tb_v_q;
    cna_pkg::pipe_t               ta_p_q, tb_p_q, nxt;
    logic [cna_pkg::TW_HALF-1:0]  xh, qh, ql, ta_qh_q, ta_lo_q;
    logic [cna_pkg::TW_HALF+3:0]  xl;
    logic [56:0]                  ph;
    logic [60:0]                  pl;
    logic [3:0]                   rh, ta_rem_q;

    cna_mul2 u_mul (
      .clk_i, .rst_ni, .en_i(en), .vld_i(tv[n-1]),
      .x0_i(64'(tp[n-1].term)), .y0_i(tp[n-1].u), .c0_i('0),
      .x1_i('0), .y1_i('0), .c1_i('0),
      .side_i(tp[n-1]), .vld_o(mv), .r0_o(mr), .r1_o(), .side_o(mp)
    );

    // high half of the dividend
    always_comb begin
      xh = mr[cna_pkg::TW-1:cna_pkg::TW_HALF];
      ph = 57'(xh) * 57'(MulH);
      qh = ph[ShH +: cna_pkg::TW_HALF];
      rh = 4'(xh - qh * (cna_pkg::TW_HALF)'(TermN));
    end

    // low half, then accumulate
    always_comb begin
      xl       = {ta_rem_q, ta_lo_q};
      pl       = 61'(xl) * 61'(MulL);
      ql       = pl[ShL +: cna_pkg::TW_HALF];
      nxt      = ta_p_q;
      nxt.term = {ta_qh_q, ql};
      nxt.m    = ta_p_q.m + 64'({ta_qh_q, ql});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ta_v_q <= 1'b0;
        tb_v_q <= 1'b0;
      end else if (en) begin
        ta_v_q <= mv;
        tb_v_q <= ta_v_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        ta_p_q   <= mp;
        ta_qh_q  <= qh;
        ta_rem_q <= rh;
        ta_lo_q  <= mr[cna_pkg::TW_HALF-1:0];
        tb_p_q   <= nxt;
      end
    end

    assign tp[n] = tb_p_q;
    assign tv[n] = tb_v_q;
  end

  // ---------------------------------------------------------------------
  // Horner for P (degree 6) and Q (degree 7) side by side. P finishes one
  // step early and rides the last step as a multiply by one.
  // ---------------------------------------------------------------------
  cna_pkg::pipe_t hp [NQ];
  logic [NQ-1:0]  hv;

  assign hp[0] = tp[NT];
  assign hv[0] = tv[NT];

  for (genvar i = 1; i < NQ; i++) begin : g_horner
    logic           mv;
    cna_pkg::q64_t  r0, r1;
    cna_pkg::pipe_t mp, nxt;

    cna_mul2 u_mul (
      .clk_i, .rst_ni, .en_i(en), .vld_i(hv[i-1]),
      .x0_i(hp[i-1].pn),
      .y0_i((i < cna_pkg::P_TERMS) ? 64'(hp[i-1].a) : cna_pkg::ONE_Q),
      .c0_i(cna_pkg::p_add(i)),
      .x1_i(hp[i-1].qd), .y1_i(64'(hp[i-1].a)), .c1_i(cna_pkg::Q_COEF[i]),
      .side_i(hp[i-1]), .vld_o(mv), .r0_o(r0), .r1_o(r1), .side_o(mp)
    );

    always_comb begin
      nxt    = mp;
      nxt.pn = r0;
      nxt.qd = r1;
    end

    assign hp[i] = nxt;
    assign hv[i] = mv;
  end

  // ---------------------------------------------------------------------
  // Continued fraction: b = a + 0.65, then b = a + c / b for c = 4..1
  // ---------------------------------------------------------------------
  cna_pkg::pipe_t cp [NC+1];
  logic [NC:0]    cv;
  cna_pkg::pipe_t cf_seed;

  always_comb begin
    cf_seed   = hp[NQ-1];
    cf_seed.b = 64'(hp[NQ-1].a) + cna_pkg::C065_Q;
  end

  assign cp[0] = cf_seed;
  assign cv[0] = hv[NQ-1];

  for (genvar j = 0; j < NC; j++) begin : g_cfrac
    logic           dv;
    cna_pkg::q64_t  dq;
    cna_pkg::pipe_t dp, nxt;

    cna_div u_div (
      .clk_i, .rst_ni, .en_i(en), .vld_i(cv[j]),
      .num_i(128'(NC - j) << (2 * cna_pkg::QF)), .den_i(cp[j].b),
      .side_i(cp[j]), .vld_o(dv), .quo_o(dq), .side_o(dp)
    );

    always_comb begin
      nxt   = dp;
      nxt.b = 64'(dp.a) + dq;
    end

    assign cp[j+1] = nxt;
    assign cv[j+1] = dv;
  end

  // ---------------------------------------------------------------------
  // Ratio: m*P / Q below sqrt(50), else m / (b * sqrt(2*pi)); 56 frac bits
  // ---------------------------------------------------------------------
  logic           fv, rv;
  cna_pkg::q64_t  mpn, dcf, rq;
  cna_pkg::pipe_t fp, rp;

  cna_mul2 u_fin (
    .clk_i, .rst_ni, .en_i(en), .vld_i(cv[NC]),
    .x0_i(cp[NC].m), .y0_i(cp[NC].pn), .c0_i('0),
    .x1_i(cp[NC].b), .y1_i(cna_pkg::SQRT2PI_Q), .c1_i('0),
    .side_i(cp[NC]), .vld_o(fv), .r0_o(mpn), .r1_o(dcf), .side_o(fp)
  );

  cna_div u_ratio (
    .clk_i, .rst_ni, .en_i(en), .vld_i(fv),
    .num_i(128'(fp.rat ? mpn : fp.m) << cna_pkg::RF),
    .den_i(fp.rat ? fp.qd : dcf),
    .side_i(fp), .vld_o(rv), .quo_o(rq), .side_o(rp)
  );

  // ---------------------------------------------------------------------
  // Tail: rounded right shift by 57 + k - OUT_FRAC_BITS, far tail to zero;
  // then clamp to 1.0 and reflect for positive x
  // ---------------------------------------------------------------------
  logic [cna_pkg::KW:0] sh;
  cna_pkg::q64_t        tail_d, tail_q, tail_c;
  logic                 tv_q, tpos_q;

  always_comb begin
    sh = (cna_pkg::KW+1)'(cna_pkg::RF + 1 - cna_pkg::OUT_FRAC_BITS)
       + (cna_pkg::KW+1)'(rp.k);
    if (rp.far || (sh >= (cna_pkg::KW+1)'(64))) begin
      tail_d = '0;
    end else begin
      tail_d = (rq + (64'd1 << (sh[5:0] - 6'd1))) >> sh[5:0];
    end
  end

  always_comb begin
    tail_c = (tail_q > cna_pkg::ONE_OUT) ? cna_pkg::ONE_OUT : tail_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      tv_q      <= rv;
      out_vld_q <= tv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tail_q <= tail_d;
      tpos_q <= rp.pos;
      prob_q <= tpos_q ? 32'(cna_pkg::ONE_OUT - tail_c) : tail_c[31:0];
    end
  end

  assign out_valid_o   = out_vld_q;
  assign probability_o = prob_q;

endmodule

// ----- design/cna_checker.sv -----
`timescale 1ns / 1ps

module cna_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [31:0] x_value_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] probability_o
);

  // a probability never passes 1.0
  a_prob_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (probability_o <= 32'h8000_0000))
    else $error("probability above one");

  // input side only backs up behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // a held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(probability_o)))
    else $error("held result changed");

  // a stalled input sample stays put
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=> (in_valid_i && $stable(x_value_i)))
    else $error("stalled input changed");

endmodule

bind cumulative_normal_approximation cna_checker u_cna_checker (.*);
